// File: rtl/load_governor_hysteresis_defines.svh
// Assertion macros for the load governor.
// Used by load_governor_hysteresis.sv; expects clk and rst_n in scope.
`ifndef LOAD_GOVERNOR_HYSTERESIS_DEFINES_SVH
`define LOAD_GOVERNOR_HYSTERESIS_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LGH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define LGH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/lgh_pkg.sv
// Shared types, constants and helpers for the load governor.
// No dependencies.
`default_nettype none

package lgh_pkg;

    localparam int TIMER_BITS = 16;
    localparam int FIELD_W    = 16;
    localparam int LEVEL_W    = 3;
    localparam int SUM_W      = ((TIMER_BITS > FIELD_W) ? TIMER_BITS : FIELD_W) + 1;

    localparam logic [LEVEL_W-1:0]    MAX_LEVEL  = LEVEL_W'(4);
    localparam logic [TIMER_BITS-1:0] TIMER_MAX  = '1;
    localparam logic [7:0]            TARGET_MIN = 8'd5;

    // Configuration register indexes
    localparam logic [2:0] CFG_ENABLE     = 3'd0;
    localparam logic [2:0] CFG_TARGET     = 3'd1;
    localparam logic [2:0] CFG_SLOW_DWELL = 3'd2;
    localparam logic [2:0] CFG_FAST_DWELL = 3'd3;
    localparam logic [2:0] CFG_HOLDOFF    = 3'd4;
    localparam logic [2:0] CFG_WARMUP     = 3'd5;

    typedef enum logic [1:0] {
        CHG_NONE    = 2'd0,
        CHG_LIGHTER = 2'd1,
        CHG_FULLER  = 2'd2
    } change_t;

    // Saturating timer advance.
    function automatic logic [TIMER_BITS-1:0] sat_add(
        input logic [TIMER_BITS-1:0] t,
        input logic [FIELD_W-1:0]    d
    );
        logic [SUM_W-1:0] s;
        s = SUM_W'(t) + SUM_W'(d);
        if (s > SUM_W'(TIMER_MAX))
            return TIMER_MAX;
        else
            return s[TIMER_BITS-1:0];
    endfunction

    // Timer strictly above a 16-bit threshold.
    function automatic logic timer_gt(
        input logic [TIMER_BITS-1:0] t,
        input logic [FIELD_W-1:0]    lim
    );
        return SUM_W'(t) > SUM_W'(lim);
    endfunction

endpackage

`default_nettype wire

// File: rtl/load_governor_hysteresis.sv
// An accepted input beat passes through the input reg and then the result reg.
// Throughput: one beat per cycle unless stalled; one more sample fits while a result waits.
// The governor state updates in the same cycle the sample leaves the input register.
// Reset (rst_n low, async): state cleared, since_step saturated, registers at defaults.
// No clearing pass; the block accepts beats right after reset.
`default_nettype none
`include "load_governor_hysteresis_defines.svh"

// Load governor with hysteresis: one sample in, one level verdict out.
// Depends on lgh_pkg and load_governor_hysteresis_defines.svh.
module load_governor_hysteresis (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // sample channel
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [lgh_pkg::FIELD_W-1:0] elapsed_ms,
    input  wire logic [lgh_pkg::FIELD_W-1:0] rate_q4,
    // result channel
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [lgh_pkg::LEVEL_W-1:0]      level,
    output logic [1:0]                       change,
    output logic                             slow_flag,
    output logic                             fast_flag,
    // configuration writes
    input  wire logic                        cfg_we,
    input  wire logic [2:0]                  cfg_index,
    input  wire logic [lgh_pkg::FIELD_W-1:0] cfg_data
);
    import lgh_pkg::*;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic                  enable_reg;
    logic [7:0]            target_reg;
    logic [FIELD_W-1:0]    slow_dwell_reg;
    logic [FIELD_W-1:0]    fast_dwell_reg;
    logic [FIELD_W-1:0]    holdoff_reg;
    logic [FIELD_W-1:0]    warmup_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg     <= 1'b1;
            target_reg     <= 8'd30;
            slow_dwell_reg <= 16'd700;
            fast_dwell_reg <= 16'd4000;
            holdoff_reg    <= 16'd1000;
            warmup_reg     <= 16'd4000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ENABLE:     enable_reg     <= cfg_data[0];
                CFG_TARGET:     target_reg     <= cfg_data[7:0];
                CFG_SLOW_DWELL: slow_dwell_reg <= cfg_data;
                CFG_FAST_DWELL: fast_dwell_reg <= cfg_data;
                CFG_HOLDOFF:    holdoff_reg    <= cfg_data;
                CFG_WARMUP:     warmup_reg     <= cfg_data;
                default:        ; // unused indexes are ignored
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Pipeline control: input register -> update -> result register.
    // The input register moves on whenever the result register is free
    // or its beat is being taken this cycle.
    // ---------------------------------------------------------------
    logic               in_vld_reg;
    logic [FIELD_W-1:0] elapsed_reg;
    logic [FIELD_W-1:0] rate_reg;
    logic               out_vld_reg;
    logic               out_free;
    logic               load;

    assign out_free = !out_vld_reg || !out_stall;
    assign load     = in_vld_reg && out_free;
    assign in_stall = in_vld_reg && !out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (!in_stall)
            in_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            elapsed_reg <= elapsed_ms;
            rate_reg    <= rate_q4;
        end
    end

    // ---------------------------------------------------------------
    // Governor state
    // ---------------------------------------------------------------
    logic [LEVEL_W-1:0]    level_reg, level_next;
    logic                  slow_act_reg, slow_act_next;
    logic [TIMER_BITS-1:0] slow_time_reg, slow_time_next;
    logic                  fast_act_reg, fast_act_next;
    logic [TIMER_BITS-1:0] fast_time_reg, fast_time_next;
    logic [TIMER_BITS-1:0] since_step_reg, since_step_next;
    logic                  warm_reg, warm_next;
    logic [TIMER_BITS-1:0] warm_time_reg, warm_time_next;

    change_t               chg_next;
    logic                  slow_next, fast_next;

    // advanced timers
    logic [TIMER_BITS-1:0] since_adv, slow_adv, fast_adv, warm_adv;
    logic [7:0]            target_eff;
    logic [FIELD_W-1:0]    slow_lim;     // 16 * target
    logic [19:0]           rate_x10;
    logic [19:0]           fast_lim;     // 256 * target
    logic                  is_slow, is_fast;
    logic                  step_ok;

    assign since_adv  = sat_add(since_step_reg, elapsed_reg);
    assign slow_adv   = slow_act_reg ? sat_add(slow_time_reg, elapsed_reg) : slow_time_reg;
    assign fast_adv   = fast_act_reg ? sat_add(fast_time_reg, elapsed_reg) : fast_time_reg;
    assign warm_adv   = warm_reg ? sat_add(warm_time_reg, elapsed_reg) : warm_time_reg;

    assign target_eff = (target_reg < TARGET_MIN) ? TARGET_MIN : target_reg;
    assign slow_lim   = {4'd0, target_eff, 4'd0};
    assign fast_lim   = {4'd0, target_eff, 8'd0};
    // rate * 10 as (rate << 3) + (rate << 1)
    assign rate_x10   = {1'b0, rate_reg, 3'd0} + {3'd0, rate_reg, 1'b0};
    assign is_slow    = rate_reg < slow_lim;
    assign is_fast    = rate_x10 > fast_lim;
    assign step_ok    = timer_gt(since_adv, holdoff_reg);

    always_comb
    begin
        level_next      = level_reg;
        slow_act_next   = slow_act_reg;
        slow_time_next  = slow_adv;
        fast_act_next   = fast_act_reg;
        fast_time_next  = fast_adv;
        since_step_next = since_adv;
        warm_next       = warm_reg;
        warm_time_next  = warm_adv;
        chg_next        = CHG_NONE;
        slow_next       = 1'b0;
        fast_next       = 1'b0;

        if (!enable_reg)
        begin
            // forced drop, not a step
            level_next = '0;
        end
        else if (rate_reg != '0)
        begin
            if (!warm_reg)
            begin
                warm_next      = 1'b1;
                warm_time_next = '0;
            end

            if (SUM_W'(warm_time_next) >= SUM_W'(warmup_reg))
            begin
                slow_next = is_slow;
                fast_next = is_fast;

                // run tracking; slow and fast are mutually exclusive
                if (is_slow)
                begin
                    fast_act_next = 1'b0;
                    if (!slow_act_reg)
                    begin
                        slow_act_next  = 1'b1;
                        slow_time_next = '0;
                    end
                end
                else
                begin
                    slow_act_next = 1'b0;
                end

                if (is_fast)
                begin
                    if (!fast_act_reg)
                    begin
                        fast_act_next  = 1'b1;
                        fast_time_next = '0;
                    end
                end
                else
                begin
                    fast_act_next = 1'b0;
                end

                if (is_slow && (level_reg < MAX_LEVEL) && step_ok &&
                    timer_gt(slow_time_next, slow_dwell_reg))
                begin
                    level_next      = level_reg + LEVEL_W'(1);
                    since_step_next = '0;
                    slow_time_next  = '0;
                    chg_next        = CHG_LIGHTER;
                end
                else if (is_fast && (level_reg != '0) && step_ok &&
                         timer_gt(fast_time_next, fast_dwell_reg))
                begin
                    level_next      = level_reg - LEVEL_W'(1);
                    since_step_next = '0;
                    fast_time_next  = '0;
                    chg_next        = CHG_FULLER;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg      <= '0;
            slow_act_reg   <= 1'b0;
            slow_time_reg  <= '0;
            fast_act_reg   <= 1'b0;
            fast_time_reg  <= '0;
            since_step_reg <= TIMER_MAX;
            warm_reg       <= 1'b0;
            warm_time_reg  <= '0;
        end
        else if (load)
        begin
            level_reg      <= level_next;
            slow_act_reg   <= slow_act_next;
            slow_time_reg  <= slow_time_next;
            fast_act_reg   <= fast_act_next;
            fast_time_reg  <= fast_time_next;
            since_step_reg <= since_step_next;
            warm_reg       <= warm_next;
            warm_time_reg  <= warm_time_next;
        end
    end

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    logic [LEVEL_W-1:0] res_level_reg;
    change_t            res_change_reg;
    logic               res_slow_reg;
    logic               res_fast_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (out_free)
            out_vld_reg <= in_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_level_reg  <= level_next;
            res_change_reg <= chg_next;
            res_slow_reg   <= slow_next;
            res_fast_reg   <= fast_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign level     = res_level_reg;
    assign change    = res_change_reg;
    assign slow_flag = res_slow_reg;
    assign fast_flag = res_fast_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `LGH_ASSERT_NOW(a_stall_only_when_blocked, in_stall, out_vld_reg && out_stall, "input stalled while result register free")
    `LGH_ASSERT_NEXT(a_lighter_steps_one, load && (chg_next == CHG_LIGHTER), level_reg == $past(level_reg) + LEVEL_W'(1), "lighter step did not raise level by one")
    `LGH_ASSERT_NEXT(a_disable_forces_zero, load && !enable_reg, (level_reg == '0) && (res_change_reg == CHG_NONE), "disabled sample did not force level to zero")
    `LGH_ASSERT_NOW(a_flags_exclusive, out_vld_reg, !(res_slow_reg && res_fast_reg) && (res_level_reg <= MAX_LEVEL), "bad result flags or level")

endmodule

`default_nettype wire

// File: tb/tb_load_governor_hysteresis.sv
`timescale 1ns / 1ps
// Self-checking testbench for load_governor_hysteresis: directed table, then random phases.
// Depends on lgh_pkg and the RTL of the block; reads no files.

module tb_load_governor_hysteresis;
    import lgh_pkg::*;

    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 160;
    localparam int QUIET_LIMIT = 4000;   // cycles with no beat on either channel
    localparam int HOLD_CYCLES = 300;    // long receiver hold-off
    localparam int SETTLE      = 4;      // margin before config writes

    // One result beat as the governor should report it.
    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        change_t            step;
        logic               slow;
        logic               fast;
    } verdict_t;

    localparam verdict_t QUIET = '{level: '0, step: CHG_NONE, slow: 1'b0, fast: 1'b0};

    // Directed row: either a register write or a sample beat, with an optional
    // hand-typed verdict for the cases that need no state to work out.
    typedef struct {
        logic                is_write;
        logic [2:0]          idx;
        logic [FIELD_W-1:0]  data;
        logic [FIELD_W-1:0]  elapsed;
        logic [FIELD_W-1:0]  rate;
        logic                typed;
        verdict_t            want;
    } plan_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [FIELD_W-1:0]   elapsed_ms = '0;
    logic [FIELD_W-1:0]   rate_q4 = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [LEVEL_W-1:0]   level;
    logic [1:0]           change;
    logic                 slow_flag;
    logic                 fast_flag;
    logic                 cfg_we = 1'b0;
    logic [2:0]           cfg_index = CFG_ENABLE;
    logic [FIELD_W-1:0]   cfg_data = '0;

    load_governor_hysteresis DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .elapsed_ms (elapsed_ms),
        .rate_q4    (rate_q4),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .level      (level),
        .change     (change),
        .slow_flag  (slow_flag),
        .fast_flag  (fast_flag),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // Shadow copy of the registers, at their reset values.
    logic                 en_r         = 1'b1;
    logic [7:0]           target_r     = 8'd30;
    logic [FIELD_W-1:0]   slow_dwell_r = 16'd700;
    logic [FIELD_W-1:0]   fast_dwell_r = 16'd4000;
    logic [FIELD_W-1:0]   holdoff_r    = 16'd1000;
    logic [FIELD_W-1:0]   warmup_r     = 16'd4000;

    // Governor state as it should be after reset.
    logic [LEVEL_W-1:0]    lvl      = '0;
    logic                  slow_run = 1'b0;
    logic [TIMER_BITS-1:0] slow_ms  = '0;
    logic                  fast_run = 1'b0;
    logic [TIMER_BITS-1:0] fast_ms  = '0;
    logic [TIMER_BITS-1:0] since_ms = '1;   // starts saturated so the first step is free
    logic                  warm_on  = 1'b0;
    logic [TIMER_BITS-1:0] warm_ms  = '0;

    verdict_t verdict_q[$];      // verdicts still owed by the block
    int       mismatches = 0;
    int       quiet_cycles = 0;
    int       in_idle_pct = 30;
    int       out_idle_pct = 30;
    bit       hold_req = 1'b0;
    int       hold_left = 0;

    initial begin
        forever #1 clk = ~clk;
    end

    // Timers clip at all-ones instead of wrapping.
    function automatic logic [TIMER_BITS-1:0] timer_advance(
        input logic [TIMER_BITS-1:0] t,
        input logic [FIELD_W-1:0]    d
    );
        logic [TIMER_BITS:0] s;
        s = {1'b0, t} + {{(TIMER_BITS + 1 - FIELD_W){1'b0}}, d};
        return s[TIMER_BITS] ? {TIMER_BITS{1'b1}} : s[TIMER_BITS-1:0];
    endfunction

    // Apply one sample to the shadow state and return the verdict it yields.
    function automatic verdict_t govern_step(
        input logic [FIELD_W-1:0] e,
        input logic [FIELD_W-1:0] r
    );
        verdict_t    v;
        int unsigned tgt;
        int unsigned rate;
        v = QUIET;
        rate = 32'(r);
        since_ms = timer_advance(since_ms, e);
        if (slow_run) slow_ms = timer_advance(slow_ms, e);
        if (fast_run) fast_ms = timer_advance(fast_ms, e);
        if (warm_on)  warm_ms = timer_advance(warm_ms, e);

        if (!en_r) begin
            // forced drop: not a step; runs and since_ms are not reset
            lvl = '0;
        end
        else if (rate != 0) begin
            if (!warm_on) begin
                warm_on = 1'b1;
                warm_ms = '0;
            end
            if (warm_ms >= warmup_r) begin
                tgt = 32'((target_r < TARGET_MIN) ? TARGET_MIN : target_r);
                v.slow = rate < tgt * 16;
                v.fast = rate * 10 > tgt * 256;   // exact 1.6x compare

                if (v.slow) begin
                    fast_run = 1'b0;
                    if (!slow_run) begin
                        slow_run = 1'b1;
                        slow_ms = '0;
                    end
                end
                else begin
                    slow_run = 1'b0;
                end
                if (v.fast) begin
                    if (!fast_run) begin
                        fast_run = 1'b1;
                        fast_ms = '0;
                    end
                end
                else begin
                    fast_run = 1'b0;
                end

                if (v.slow && lvl < MAX_LEVEL && slow_ms > slow_dwell_r
                        && since_ms > holdoff_r) begin
                    lvl = lvl + LEVEL_W'(1);
                    since_ms = '0;
                    slow_ms = '0;
                    v.step = CHG_LIGHTER;
                end
                else if (v.fast && lvl != '0 && fast_ms > fast_dwell_r
                        && since_ms > holdoff_r) begin
                    lvl = lvl - LEVEL_W'(1);
                    since_ms = '0;
                    fast_ms = '0;
                    v.step = CHG_FULLER;
                end
            end
        end
        v.level = lvl;
        return v;
    endfunction

    // Offer one sample beat; idles at random first. Leaves in_valid high.
    task automatic send_sample(
        input logic [FIELD_W-1:0] e,
        input logic [FIELD_W-1:0] r,
        input logic               typed,
        input verdict_t           want
    );
        verdict_t v;
        while ($urandom_range(99) < in_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        elapsed_ms <= e;
        rate_q4    <= r;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        // accepted at this edge
        v = govern_step(e, r);
        verdict_q.push_back(typed ? want : v);
    endtask

    // Sender pause: every owed verdict back, then let the pipe go quiet.
    task automatic settle_idle();
        in_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // One register write; caller drops cfg_we after the last of a batch.
    task automatic write_reg(input logic [2:0] idx, input logic [FIELD_W-1:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        case (idx)
            CFG_ENABLE:     en_r = d[0];
            CFG_TARGET:     target_r = d[7:0];
            CFG_SLOW_DWELL: slow_dwell_r = d;
            CFG_FAST_DWELL: fast_dwell_r = d;
            CFG_HOLDOFF:    holdoff_r = d;
            CFG_WARMUP:     warmup_r = d;
            default: ;
        endcase
    endtask

    // Millisecond register value, biased toward short dwells so steps happen.
    function automatic logic [FIELD_W-1:0] pick_ms();
        int unsigned k;
        k = $urandom_range(9);
        if (k == 0) return '0;
        if (k == 1) return '1;
        if (k == 2) return FIELD_W'($urandom_range(65535));
        return FIELD_W'($urandom_range(3000));
    endfunction

    // Receiver: random stalls, plus one long hold-off on request.
    always @(posedge clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else begin
            out_stall <= ($urandom_range(99) < out_idle_pct);
        end
    end

    // Result checker and watchdog.
    always @(posedge clk) begin
        verdict_t want;
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("status: fail");
                $finish;
            end
            else if (out_valid && !out_stall) begin
                if (verdict_q.size() == 0) begin
                    $error("result beat with no verdict owed: level %0d", level);
                    mismatches++;
                end
                else begin
                    want = verdict_q.pop_front();
                    if (level !== want.level) begin
                        $error("level: expected %0d, actual %0d", want.level, level);
                        mismatches++;
                    end
                    if (change !== want.step) begin
                        $error("change: expected %0d, actual %0d", want.step, change);
                        mismatches++;
                    end
                    if (slow_flag !== want.slow) begin
                        $error("slow_flag: expected %0d, actual %0d", want.slow, slow_flag);
                        mismatches++;
                    end
                    if (fast_flag !== want.fast) begin
                        $error("fast_flag: expected %0d, actual %0d", want.fast, fast_flag);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Directed table. Defaults after reset: target 30 (slow below 480, fast above
    // 768), slow dwell 700, fast dwell 4000, holdoff 1000, warm-up 4000.
    plan_row_t plan [29] = '{
        // unknown rate right after reset; since_ms pinned at max
        '{1'b0, CFG_ENABLE, 16'd0, 16'd65535, 16'd0,     1'b1, QUIET},
        // first nonzero rate starts warm-up, no verdict
        '{1'b0, CFG_ENABLE, 16'd0, 16'd0,     16'd100,   1'b1, QUIET},
        // one ms short of the warm-up end
        '{1'b0, CFG_ENABLE, 16'd0, 16'd3999,  16'd100,   1'b1, QUIET},
        // warm-up over: slow run opens
        '{1'b0, CFG_ENABLE, 16'd0, 16'd1,     16'd100,   1'b0, QUIET},
        // slow dwell just exceeded: step lighter
        '{1'b0, CFG_ENABLE, 16'd0, 16'd701,   16'd1,     1'b0, QUIET},
        '{1'b0, CFG_ENABLE, 16'd0, 16'd65535, 16'd0,     1'b0, QUIET},
        // slow time saturated, last value below target
        '{1'b0, CFG_ENABLE, 16'd0, 16'd65535, 16'd479,   1'b0, QUIET},
        // exactly target, and exactly 1.6x target: neither slow nor fast
        '{1'b0, CFG_ENABLE, 16'd0, 16'd1,     16'd480,   1'b0, QUIET},
        '{1'b0, CFG_ENABLE, 16'd0, 16'd1,     16'd768,   1'b0, QUIET},
        // one above 1.6x: fast run opens
        '{1'b0, CFG_ENABLE, 16'd0, 16'd1,     16'd769,   1'b0, QUIET},
        '{1'b0, CFG_ENABLE, 16'd0, 16'd4001,  16'd65535, 1'b0, QUIET},
        '{1'b0, CFG_ENABLE, 16'd0, 16'd65535, 16'd65535, 1'b0, QUIET},
        // already at full quality: no fuller step
        '{1'b0, CFG_ENABLE, 16'd0, 16'd65535, 16'd65535, 1'b0, QUIET},
        // climb to the lightest level and sit there
        '{1'b0, CFG_ENABLE, 16'd0, 16'd65535, 16'd1,     1'b0, QUIET},
        '{1'b0, CFG_ENABLE, 16'd0, 16'd65535, 16'd1,     1'b0, QUIET},
        '{1'b0, CFG_ENABLE, 16'd0, 16'd65535, 16'd1,     1'b0, QUIET},
        '{1'b0, CFG_ENABLE, 16'd0, 16'd65535, 16'd1,     1'b0, QUIET},
        '{1'b0, CFG_ENABLE, 16'd0, 16'd65535, 16'd1,     1'b0, QUIET},
        '{1'b0, CFG_ENABLE, 16'd0, 16'd65535, 16'd1,     1'b0, QUIET},
        // disabled: level forced to zero without a step
        '{1'b1, CFG_ENABLE, 16'd0, 16'd0,     16'd0,     1'b0, QUIET},
        '{1'b0, CFG_ENABLE, 16'd0, 16'd5,     16'd1,     1'b1, QUIET},
        '{1'b1, CFG_ENABLE, 16'd1, 16'd0,     16'd0,     1'b0, QUIET},
        // target below the floor acts as 5: slow below 80, fast above 128
        '{1'b1, CFG_TARGET, 16'd0, 16'd0,     16'd0,     1'b0, QUIET},
        '{1'b0, CFG_ENABLE, 16'd0, 16'd0,     16'd79,    1'b0, QUIET},
        '{1'b0, CFG_ENABLE, 16'd0, 16'd0,     16'd80,    1'b0, QUIET},
        '{1'b0, CFG_ENABLE, 16'd0, 16'd0,     16'd129,   1'b0, QUIET},
        // widest target the register holds
        '{1'b1, CFG_TARGET, 16'd255, 16'd0,   16'd0,     1'b0, QUIET},
        '{1'b0, CFG_ENABLE, 16'd0, 16'd0,     16'd65535, 1'b0, QUIET},
        '{1'b0, CFG_ENABLE, 16'd0, 16'd0,     16'd4079,  1'b0, QUIET}
    };

    initial begin
        logic               en;
        logic [7:0]         tg;
        logic [FIELD_W-1:0] sd, fd, ho, wu;
        logic [FIELD_W-1:0] e, r;
        int unsigned        tgt, slow_top, fast_min, mode, blen, sent;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i]) begin
            if (plan[i].is_write) begin
                settle_idle();
                write_reg(plan[i].idx, plan[i].data);
                cfg_we <= 1'b0;
            end
            else begin
                send_sample(plan[i].elapsed, plan[i].rate, plan[i].typed, plan[i].want);
            end
        end

        // Random phases: each one rewrites every register, then streams bursts
        // of slow / fast / in-band samples so the dwell timers actually fill.
        for (int ph = 0; ph < PHASES; ph++) begin
            settle_idle();
            if (ph == 0) begin
                // all-zero timings, lowest legal target
                en = 1'b1; tg = 8'd5; sd = '0; fd = '0; ho = '0; wu = '0;
            end
            else if (ph == 1) begin
                // longest timings, widest target
                en = 1'b1; tg = 8'd255; sd = '1; fd = '1; ho = '1; wu = '1;
            end
            else begin
                en = (ph == PHASES - 2) ? 1'b0 : ($urandom_range(15) != 0);
                case ($urandom_range(5))
                    0:       tg = 8'($urandom_range(4));
                    1:       tg = 8'd240;
                    default: tg = 8'($urandom_range(240, 5));
                endcase
                sd = pick_ms();
                fd = pick_ms();
                ho = pick_ms();
                wu = pick_ms();
            end
            write_reg(CFG_ENABLE, {{(FIELD_W - 1){1'b0}}, en});
            write_reg(CFG_TARGET, {8'd0, tg});
            write_reg(CFG_SLOW_DWELL, sd);
            write_reg(CFG_FAST_DWELL, fd);
            write_reg(CFG_HOLDOFF, ho);
            write_reg(CFG_WARMUP, wu);
            cfg_we <= 1'b0;

            // one phase runs flat out on both sides
            in_idle_pct  = (ph == 5) ? 0 : 30;
            out_idle_pct = (ph == 5) ? 0 : 30;
            // one phase opens with a long receiver hold-off to back the block up
            if (ph == 3) hold_req = 1'b1;

            tgt      = 32'((tg < TARGET_MIN) ? TARGET_MIN : tg);
            slow_top = tgt * 16 - 1;
            fast_min = (tgt * 256) / 10 + 1;
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                mode = $urandom_range(99);
                blen = $urandom_range(24, 1);
                for (int k = 0; k < blen && sent < PHASE_ITEMS; k++) begin
                    case ($urandom_range(19))
                        0, 1:    e = '0;
                        2:       e = '1;
                        3, 4:    e = FIELD_W'($urandom_range(65535));
                        default: e = FIELD_W'($urandom_range(800, 1));
                    endcase
                    if (mode < 35)
                        r = FIELD_W'($urandom_range(slow_top, 1));
                    else if (mode < 65)
                        r = FIELD_W'($urandom_range(65535, fast_min));
                    else if (mode < 75)
                        r = FIELD_W'($urandom_range(fast_min - 1, slow_top + 1));
                    else if (mode < 85) begin
                        case ($urandom_range(3))
                            0:       r = FIELD_W'(slow_top);
                            1:       r = FIELD_W'(slow_top + 1);
                            2:       r = FIELD_W'(fast_min - 1);
                            default: r = FIELD_W'(fast_min);
                        endcase
                    end
                    else begin
                        case ($urandom_range(3))
                            0:       r = '0;
                            1:       r = '1;
                            default: r = FIELD_W'($urandom_range(65535));
                        endcase
                    end
                    // the odd unknown-rate beat inside a run
                    if ($urandom_range(19) == 0) r = '0;
                    send_sample(e, r, 1'b0, QUIET);
                    sent++;
                end
            end
        end

        in_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
